### src/bba_pkg.sv
// shared constants, types and helpers of the buddy block allocator
`default_nettype none

package bba_pkg;

    localparam int HEAP_EXP      = 16;
    localparam int MIN_BLOCK_EXP = 4;
    localparam int TREE_LEVELS   = HEAP_EXP - MIN_BLOCK_EXP + 1;
    localparam int NODE_COUNT    = (1 << TREE_LEVELS) - 1;
    localparam int IDX_W         = TREE_LEVELS;
    localparam int LVL_W         = $clog2(TREE_LEVELS);
    localparam int POS_W         = TREE_LEVELS - 1;
    localparam int EXP_W         = $clog2(HEAP_EXP + 1);
    localparam int BYTES_W       = HEAP_EXP + 1;
    localparam logic [BYTES_W-1:0] HEAP_BYTES = BYTES_W'(1) << HEAP_EXP;

    typedef enum logic [1:0] {
        ST_FREE  = 2'd0,
        ST_USED  = 2'd1,
        ST_SPLIT = 2'd2
    } node_st_t;

    typedef enum logic [1:0] {
        RES_OK         = 2'd0,
        RES_ALLOC_FAIL = 2'd1,
        RES_FREE_MISS  = 2'd2
    } res_status_t;

    localparam logic OP_ALLOC = 1'b0;

    // tree index of the node at depth d, position p within that depth
    function automatic logic [IDX_W-1:0] node_idx(input logic [LVL_W-1:0] d,
                                                  input logic [POS_W-1:0] p);
        node_idx = ((IDX_W'(1) << d) - IDX_W'(1)) + IDX_W'(p);
    endfunction

endpackage

`default_nettype wire

### src/buddy_block_allocator.sv
// top level of the buddy block allocator: tree state memory and its sequencer
//
// channel | dir | handshake          | payload
// s_      | in  | s_tvalid/s_tready  | s_tuser operation, s_tdata size and offset
// m_      | out | m_tvalid/m_tready  | m_tdata status, offset, sizes, totals
//
// an allocate walks the tree depth first, reading each node visited (S_A_RD)
// and deciding on it (S_A_EV), with a climb step (S_A_CLIMB) on a skip and one
// write per level when marking (S_A_MARK); on an empty heap the root is free and
// the block is taken at once, and the walk grows longer as the tree fragments
// a free walks down level by level, then merges upward while the buddy is free
// after reset a clearing pass marks all 8191 nodes free; no item
// is taken until it ends
// a finished result waits in the output register; the next item is taken
// while it waits, and the block only stalls when a second result is ready
`default_nettype none

module buddy_block_allocator import bba_pkg::*; (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    // request_size [16:0], block_offset [32:17]
    input  wire  [39:0] s_tdata,
    // operation [0]
    input  wire  [0:0]  s_tuser,
    output logic        m_tvalid,
    input  wire         m_tready,
    // status [1:0], offset [17:2], block_bytes [34:18], used_bytes [51:35],
    // free_bytes [68:52]
    output logic [71:0] m_tdata
);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_A_RD, S_A_EV, S_A_CLIMB, S_A_MARK,
        S_F_RD, S_F_EV, S_M_RD, S_M_EV, S_DONE
    } state_t;

    state_t            state_reg;
    logic [IDX_W-1:0]  clr_cnt_reg;
    logic [LVL_W-1:0]  d_reg;      // depth of the node in hand
    logic [POS_W-1:0]  p_reg;      // position within that depth
    logic [LVL_W-1:0]  lvl_reg;    // target depth of an allocate
    logic [EXP_W-1:0]  exp_reg;    // block size exponent in hand
    logic [15:0]       off_reg;
    logic [BYTES_W-1:0] used_reg;

    res_status_t       status_reg;
    logic [15:0]       res_off_reg;
    logic [BYTES_W-1:0] res_bytes_reg;
    logic              m_tvalid_reg;
    logic [BYTES_W-1:0] out_used_reg;
    logic [BYTES_W-1:0] out_free_reg;

    // tree state memory
    node_st_t          mem [NODE_COUNT];
    node_st_t          rd_data_reg;
    logic [IDX_W-1:0]  rd_addr;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    node_st_t          wr_data;

    // input fields
    logic              in_op;
    logic [16:0]       in_size;
    logic [15:0]       in_off;
    logic [EXP_W-1:0]  alloc_exp;
    logic [EXP_W-1:0]  off_tz;
    logic [BYTES_W-1:0] free_now;

    assign in_op    = s_tuser[0];
    assign in_size  = s_tdata[16:0];
    assign in_off   = s_tdata[32:17];
    assign free_now = HEAP_BYTES - used_reg;
    assign s_tready = (state_reg == S_IDLE);

    // rounded allocation exponent, at least the minimum block
    always_comb begin
        alloc_exp = EXP_W'(HEAP_EXP);
        for (int i = HEAP_EXP; i >= MIN_BLOCK_EXP; i--) begin
            if ((BYTES_W'(1) << i) >= in_size) begin
                alloc_exp = EXP_W'(i);
            end
        end
    end

    // alignment of the offset to free, heap size when zero
    always_comb begin
        off_tz = EXP_W'(HEAP_EXP);
        for (int i = 15; i >= 0; i--) begin
            if (in_off[i]) begin
                off_tz = EXP_W'(i);
            end
        end
    end

    // memory port control
    always_comb begin
        rd_addr = node_idx(d_reg, p_reg);
        wr_en   = 1'b0;
        wr_addr = node_idx(d_reg, p_reg);
        wr_data = ST_FREE;
        case (state_reg)
            S_CLEAR: begin
                wr_en   = 1'b1;
                wr_addr = clr_cnt_reg;
            end
            S_A_MARK: begin
                wr_en   = 1'b1;
                wr_data = (d_reg == lvl_reg) ? ST_USED : ST_SPLIT;
            end
            S_F_EV: begin
                // free the first used block on the way down
                wr_en = (rd_data_reg == ST_USED);
            end
            S_M_RD: begin
                rd_addr = node_idx(d_reg, p_reg ^ POS_W'(1));
            end
            S_M_EV: begin
                // both halves free: the parent becomes free
                wr_en   = (rd_data_reg == ST_FREE);
                wr_addr = node_idx(d_reg - LVL_W'(1), p_reg >> 1);
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // sequencer and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLEAR;
            clr_cnt_reg  <= '0;
            used_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            // a result leaving while the next one is loaded is handled in S_DONE
            if (m_tvalid_reg && m_tready && state_reg != S_DONE) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                S_CLEAR: begin
                    clr_cnt_reg <= clr_cnt_reg + IDX_W'(1);
                    if (clr_cnt_reg == IDX_W'(NODE_COUNT - 1)) begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (s_tvalid) begin
                        res_bytes_reg <= '0;
                        if (in_op == OP_ALLOC) begin
                            res_off_reg <= '0;
                            if (in_size == '0 || in_size > free_now) begin
                                status_reg <= RES_ALLOC_FAIL;
                                state_reg  <= S_DONE;
                            end else begin
                                exp_reg   <= alloc_exp;
                                lvl_reg   <= LVL_W'(EXP_W'(HEAP_EXP) - alloc_exp);
                                d_reg     <= '0;
                                p_reg     <= '0;
                                state_reg <= S_A_RD;
                            end
                        end else begin
                            off_reg     <= in_off;
                            res_off_reg <= in_off;
                            if (off_tz < EXP_W'(MIN_BLOCK_EXP)) begin
                                status_reg <= RES_FREE_MISS;
                                state_reg  <= S_DONE;
                            end else begin
                                exp_reg   <= off_tz;
                                d_reg     <= LVL_W'(EXP_W'(HEAP_EXP) - off_tz);
                                p_reg     <= POS_W'(in_off >> off_tz);
                                state_reg <= S_F_RD;
                            end
                        end
                    end
                end
                S_A_RD: begin
                    state_reg <= S_A_EV;
                end
                S_A_EV: begin
                    if (rd_data_reg == ST_FREE) begin
                        // whole subtree free: take its leftmost block
                        p_reg       <= p_reg << (lvl_reg - d_reg);
                        d_reg       <= lvl_reg;
                        res_off_reg <= 16'(32'(p_reg << (lvl_reg - d_reg)) << exp_reg);
                        state_reg   <= S_A_MARK;
                    end else if (rd_data_reg == ST_SPLIT && d_reg != lvl_reg) begin
                        d_reg     <= d_reg + LVL_W'(1);
                        p_reg     <= p_reg << 1;
                        state_reg <= S_A_RD;
                    end else begin
                        state_reg <= S_A_CLIMB;
                    end
                end
                S_A_CLIMB: begin
                    if (d_reg == '0) begin
                        status_reg  <= RES_ALLOC_FAIL;
                        res_off_reg <= '0;
                        state_reg   <= S_DONE;
                    end else if (p_reg[0]) begin
                        d_reg <= d_reg - LVL_W'(1);
                        p_reg <= p_reg >> 1;
                    end else begin
                        p_reg     <= p_reg + POS_W'(1);
                        state_reg <= S_A_RD;
                    end
                end
                S_A_MARK: begin
                    if (d_reg == '0) begin
                        status_reg    <= RES_OK;
                        res_bytes_reg <= BYTES_W'(1) << exp_reg;
                        used_reg      <= used_reg + (BYTES_W'(1) << exp_reg);
                        state_reg     <= S_DONE;
                    end else begin
                        d_reg <= d_reg - LVL_W'(1);
                        p_reg <= p_reg >> 1;
                    end
                end
                S_F_RD: begin
                    state_reg <= S_F_EV;
                end
                S_F_EV: begin
                    if (rd_data_reg == ST_USED) begin
                        status_reg    <= RES_OK;
                        res_bytes_reg <= BYTES_W'(1) << exp_reg;
                        used_reg      <= (used_reg >= (BYTES_W'(1) << exp_reg)) ?
                                         used_reg - (BYTES_W'(1) << exp_reg) : '0;
                        state_reg     <= S_M_RD;
                    end else if (exp_reg == EXP_W'(MIN_BLOCK_EXP)) begin
                        status_reg <= RES_FREE_MISS;
                        state_reg  <= S_DONE;
                    end else begin
                        exp_reg   <= exp_reg - EXP_W'(1);
                        d_reg     <= d_reg + LVL_W'(1);
                        p_reg     <= POS_W'(off_reg >> (exp_reg - EXP_W'(1)));
                        state_reg <= S_F_RD;
                    end
                end
                S_M_RD: begin
                    state_reg <= (d_reg == '0) ? S_DONE : S_M_EV;
                end
                S_M_EV: begin
                    if (rd_data_reg == ST_FREE) begin
                        d_reg     <= d_reg - LVL_W'(1);
                        p_reg     <= p_reg >> 1;
                        state_reg <= S_M_RD;
                    end else begin
                        state_reg <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        out_used_reg <= used_reg;
                        out_free_reg <= free_now;
                        state_reg    <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    logic [15:0]        out_off_reg;
    logic [BYTES_W-1:0] out_bytes_reg;
    res_status_t        out_status_reg;

    always_ff @(posedge aclk) begin
        if (state_reg == S_DONE && (!m_tvalid_reg || m_tready)) begin
            out_status_reg <= status_reg;
            out_off_reg    <= res_off_reg;
            out_bytes_reg  <= res_bytes_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {3'b000, out_free_reg, out_used_reg, out_bytes_reg,
                       out_off_reg, out_status_reg};

    // the used total never exceeds the heap
    assert property (@(posedge aclk) disable iff (!aresetn) used_reg <= HEAP_BYTES)
        else $error("used total beyond heap size");

    // no tree write while an item can be taken
    assert property (@(posedge aclk) disable iff (!aresetn) s_tready |-> !wr_en)
        else $error("tree written while idle");

    // a failed result carries no block size
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[1:0] != RES_OK) |-> (m_tdata[34:18] == '0))
        else $error("failed result with a block size");

    // reported totals always add up to the heap
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (BYTES_W'(m_tdata[51:35] + m_tdata[68:52]) == HEAP_BYTES))
        else $error("used and free totals disagree");

endmodule

`default_nettype wire

### dv/tb.sv
// self-checking testbench of the buddy block allocator: directed table, then random traffic
`default_nettype none

module tb;
    import bba_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT_CYCLES = 40_000_000;
    localparam int RAND_ITEMS   = 1300;
    localparam logic OP_FREE    = 1'b1;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] offset;
        logic [16:0] block_bytes;
        logic [16:0] used_bytes;
        logic [16:0] free_bytes;
    } alloc_res_t;

    typedef struct {
        logic        op;
        logic [16:0] size;
        logic [15:0] offs;
        logic        known;   // expected result typed in
        alloc_res_t  res;
    } stim_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;
    logic [0:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;

    buddy_block_allocator u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // predictor state: tree of node states and bytes held
    node_st_t    tree_st [NODE_COUNT];
    logic [16:0] held_bytes;
    alloc_res_t  pending_res [$];
    int          n_errors = 0;
    int          cycle_cnt = 0;
    logic [15:0] live_offs [$];   // offsets of blocks believed allocated

    function automatic alloc_res_t pack_res(logic [1:0] st, logic [15:0] off,
                                            logic [16:0] bytes);
        alloc_res_t r;
        r.status      = st;
        r.offset      = off;
        r.block_bytes = bytes;
        r.used_bytes  = held_bytes;
        r.free_bytes  = HEAP_BYTES - held_bytes;
        return r;
    endfunction

    function automatic bit path_clear(int node);
        int n;
        n = node;
        while (n != 0) begin
            n = (n - 1) / 2;
            if (tree_st[n] == ST_USED) return 0;
        end
        return 1;
    endfunction

    function automatic alloc_res_t predict_alloc(logic [16:0] size);
        int e;
        int cnt;
        int node;
        int n;
        e = MIN_BLOCK_EXP;
        if (size == 0 || size > HEAP_BYTES - held_bytes)
            return pack_res(RES_ALLOC_FAIL, '0, '0);
        while ((longint'(1) << e) < size) e++;
        if (e > HEAP_EXP) return pack_res(RES_ALLOC_FAIL, '0, '0);
        cnt = 1 << (HEAP_EXP - e);
        for (int k = 0; k < cnt; k++) begin
            node = cnt - 1 + k;
            if (tree_st[node] == ST_FREE && path_clear(node)) begin
                n = node;
                while (n != 0) begin
                    n = (n - 1) / 2;
                    tree_st[n] = ST_SPLIT;
                end
                tree_st[node] = ST_USED;
                held_bytes += 17'(1 << e);
                return pack_res(RES_OK, 16'(k << e), 17'(1 << e));
            end
        end
        return pack_res(RES_ALLOC_FAIL, '0, '0);
    endfunction

    function automatic alloc_res_t predict_free(logic [15:0] off);
        int top_exp;
        int node;
        int bud;
        int par;
        top_exp = HEAP_EXP;
        if (off != 0) begin
            top_exp = 0;
            while (top_exp < HEAP_EXP && ((off >> (top_exp + 1)) << (top_exp + 1)) == off)
                top_exp++;
        end
        for (int k = top_exp; k >= MIN_BLOCK_EXP; k--) begin
            node = int'(off >> k) + ((1 << (HEAP_EXP - k)) - 1);
            if (tree_st[node] == ST_USED) begin
                tree_st[node] = ST_FREE;
                // merge free buddies upward
                while (node != 0) begin
                    bud = (node & 1) ? node + 1 : node - 1;
                    par = (node - 1) / 2;
                    if (tree_st[bud] != ST_FREE || tree_st[par] != ST_SPLIT) break;
                    tree_st[par] = ST_FREE;
                    node = par;
                end
                held_bytes = (held_bytes >= 17'(1 << k)) ? held_bytes - 17'(1 << k) : '0;
                return pack_res(RES_OK, off, 17'(1 << k));
            end
        end
        return pack_res(RES_FREE_MISS, off, '0);
    endfunction

    // sender: bursts with random gaps
    int burst_left = 0;

    task automatic send_item(logic op, logic [16:0] size, logic [15:0] offs);
        alloc_res_t r;
        int         gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 16);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {7'b0, offs, size};
        do @(posedge aclk); while (!s_tready);
        burst_left--;
        r = (op == OP_ALLOC) ? predict_alloc(size) : predict_free(offs);
        if (op == OP_ALLOC && r.status == RES_OK) live_offs.push_back(r.offset);
        pending_res.push_back(r);
    endtask

    // receiver stall pattern: phases of always ready, random, and long stalls
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        case ((cycle_cnt >> 9) % 3)
            0: m_tready <= 1'b1;
            1: m_tready <= ($urandom_range(0, 1) == 1);
            default: m_tready <= ($urandom_range(0, 7) == 0);
        endcase
        if (cycle_cnt >= LIMIT_CYCLES) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // result checker
    always @(posedge aclk) begin
        alloc_res_t got;
        alloc_res_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.status      = m_tdata[1:0];
            got.offset      = m_tdata[17:2];
            got.block_bytes = m_tdata[34:18];
            got.used_bytes  = m_tdata[51:35];
            got.free_bytes  = m_tdata[68:52];
            if (pending_res.size() == 0) begin
                $display("%0t unexpected result %h", $time, got);
                n_errors++;
            end else begin
                want = pending_res.pop_front();
                if (got.status !== want.status) begin
                    $display("%0t status exp %0d got %0d", $time, want.status, got.status);
                    n_errors++;
                end
                if (got.offset !== want.offset) begin
                    $display("%0t offset exp %h got %h", $time, want.offset, got.offset);
                    n_errors++;
                end
                if (got.block_bytes !== want.block_bytes) begin
                    $display("%0t block_bytes exp %0d got %0d", $time,
                             want.block_bytes, got.block_bytes);
                    n_errors++;
                end
                if (got.used_bytes !== want.used_bytes) begin
                    $display("%0t used_bytes exp %0d got %0d", $time,
                             want.used_bytes, got.used_bytes);
                    n_errors++;
                end
                if (got.free_bytes !== want.free_bytes) begin
                    $display("%0t free_bytes exp %0d got %0d", $time,
                             want.free_bytes, got.free_bytes);
                    n_errors++;
                end
            end
        end
    end

    // directed table; known rows hold results readable at a glance
    stim_row_t dir_tab [] = '{
        '{OP_ALLOC, 17'd0,     16'h0000, 1'b1, '{RES_ALLOC_FAIL, 16'h0, 17'd0, 17'd0, 17'h10000}},
        '{OP_FREE,  17'd0,     16'h0000, 1'b1, '{RES_FREE_MISS, 16'h0, 17'd0, 17'd0, 17'h10000}},
        '{OP_FREE,  17'h1ffff, 16'hffff, 1'b1, '{RES_FREE_MISS, 16'hffff, 17'd0, 17'd0, 17'h10000}},
        '{OP_ALLOC, 17'h1ffff, 16'hffff, 1'b1, '{RES_ALLOC_FAIL, 16'h0, 17'd0, 17'd0, 17'h10000}},
        '{OP_ALLOC, 17'h10001, 16'h0000, 1'b1, '{RES_ALLOC_FAIL, 16'h0, 17'd0, 17'd0, 17'h10000}},
        '{OP_ALLOC, 17'h10000, 16'h0000, 1'b1, '{RES_OK, 16'h0, 17'h10000, 17'h10000, 17'd0}},
        '{OP_ALLOC, 17'd1,     16'h0000, 1'b1, '{RES_ALLOC_FAIL, 16'h0, 17'd0, 17'h10000, 17'd0}},
        '{OP_FREE,  17'd0,     16'h0010, 1'b1, '{RES_FREE_MISS, 16'h10, 17'd0, 17'h10000, 17'd0}},
        '{OP_FREE,  17'd0,     16'h0000, 1'b1, '{RES_OK, 16'h0, 17'h10000, 17'd0, 17'h10000}},
        '{OP_ALLOC, 17'd1,     16'h0000, 1'b1, '{RES_OK, 16'h0, 17'd16, 17'd16, 17'hfff0}},
        '{OP_ALLOC, 17'd17,    16'h0000, 1'b0, '0},
        '{OP_ALLOC, 17'd16,    16'h0000, 1'b0, '0},
        '{OP_ALLOC, 17'h8000,  16'h0000, 1'b0, '0},
        '{OP_ALLOC, 17'h8000,  16'h0000, 1'b0, '0},   // no room at that size
        '{OP_FREE,  17'd0,     16'h0008, 1'b0, '0},   // not aligned to minimum block
        '{OP_FREE,  17'd0,     16'h0024, 1'b0, '0},   // inside a block
        '{OP_FREE,  17'd0,     16'h0020, 1'b0, '0},
        '{OP_FREE,  17'd0,     16'h0020, 1'b0, '0},   // already free
        '{OP_FREE,  17'd0,     16'h0000, 1'b0, '0},
        '{OP_FREE,  17'd0,     16'h0010, 1'b0, '0},
        '{OP_FREE,  17'd0,     16'h8000, 1'b0, '0},
        '{OP_ALLOC, 17'd100,   16'h0000, 1'b0, '0},
        '{OP_FREE,  17'd0,     16'h0000, 1'b0, '0}
    };

    initial begin
        alloc_res_t   r;
        logic [16:0]  sz;
        logic [15:0]  off;
        int           idx;
        for (int i = 0; i < NODE_COUNT; i++) tree_st[i] = ST_FREE;
        held_bytes = '0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (dir_tab[i]) begin
            send_item(dir_tab[i].op, dir_tab[i].size, dir_tab[i].offs);
            if (dir_tab[i].known) begin
                // typed-in result overrides the predicted one
                r = dir_tab[i].res;
                pending_res[pending_res.size() - 1] = r;
            end
        end
        live_offs.delete();
        for (int i = 0; i < NODE_COUNT; i++) tree_st[i] = tree_st[i];

        for (int n = 0; n < RAND_ITEMS; n++) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: begin
                    // mostly small sizes, a few large ones
                    if ($urandom_range(0, 15) == 0) sz = 17'($urandom_range(0, 17'h1ffff));
                    else sz = 17'($urandom_range(1, 1 << $urandom_range(0, 11)));
                    send_item(OP_ALLOC, sz, 16'($urandom));
                end
                4, 5, 6, 7: begin
                    if (live_offs.size() > 0) begin
                        idx = $urandom_range(0, live_offs.size() - 1);
                        off = live_offs[idx];
                        live_offs.delete(idx);
                    end else off = 16'($urandom);
                    send_item(OP_FREE, 17'($urandom), off);
                end
                8: send_item(OP_FREE, 17'($urandom), 16'($urandom) & 16'hfff0);
                default: send_item(OP_FREE, 17'($urandom), 16'($urandom));
            endcase
        end
        s_tvalid <= 1'b0;

        while (pending_res.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        if (n_errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

`default_nettype wire

### files.f
src/bba_pkg.sv
src/buddy_block_allocator.sv
dv/tb.sv
